@@ rtl/pftf_pkg.sv @@
// ----------------------------------------------------------------------------
// pftf_pkg
// Shared types, codes and helpers for the fragment test and fog pipeline.
// ----------------------------------------------------------------------------
package pftf_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned RAW_W  = 32;
  localparam int unsigned PROD_W = 2 * CHAN_W;

  // Multiply-by-reciprocal for the divide by 255 in the fog blend
  localparam logic [15:0] DIV255_MUL = 16'h8081;
  localparam int unsigned DIV255_SHIFT = 23;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // Configuration register indexes
  localparam logic [2:0] REG_STAGE_EN   = 3'd0;
  localparam logic [2:0] REG_DEPTH_MIN  = 3'd1;
  localparam logic [2:0] REG_DEPTH_MAX  = 3'd2;
  localparam logic [2:0] REG_ALPHA_SET  = 3'd3;
  localparam logic [2:0] REG_FOG_RGB    = 3'd4;
  localparam logic [2:0] REG_CTEST_FUNC = 3'd5;
  localparam logic [2:0] REG_CTEST_REF  = 3'd6;
  localparam logic [2:0] REG_CTEST_MASK = 3'd7;

  // stage_enables bit positions
  localparam int unsigned EN_DEPTH  = 0;
  localparam int unsigned EN_FOG    = 1;
  localparam int unsigned EN_CTEST  = 2;
  localparam int unsigned EN_CLEAR  = 3;
  localparam int unsigned EN_AMASK  = 4;

  typedef enum logic [2:0] {
    AFN_NEVER  = 3'd0,
    AFN_ALWAYS = 3'd1,
    AFN_EQ     = 3'd2,
    AFN_NE     = 3'd3,
    AFN_LT     = 3'd4,
    AFN_LE     = 3'd5,
    AFN_GT     = 3'd6,
    AFN_GE     = 3'd7
  } alpha_func_t;

  typedef enum logic [1:0] {
    CFN_NEVER  = 2'd0,
    CFN_ALWAYS = 2'd1,
    CFN_EQ     = 2'd2,
    CFN_NE     = 2'd3
  } ctest_func_t;

  // Per-fragment control traveling alongside the color lanes
  typedef struct packed {
    logic              valid;
    logic              keep;
    logic [CHAN_W-1:0] alpha;
  } frag_ctl_t;

  // Saturate a signed 32-bit channel to 0..255
  function automatic logic [CHAN_W-1:0] clamp_chan(input logic [RAW_W-1:0] raw);
    logic [CHAN_W-1:0] res;
    if (raw[RAW_W-1]) begin
      res = '0;
    end else if (|raw[RAW_W-2:CHAN_W]) begin
      res = CHAN_MAX;
    end else begin
      res = raw[CHAN_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/pftf_lane.sv @@
// ----------------------------------------------------------------------------
// pftf_lane
// One color lane: clamp, then optional fog blend (c*f + fc*(255-f)) / 255 over
// two register stages, one word per cycle.
// ----------------------------------------------------------------------------
module pftf_lane
  import pftf_pkg::*;
(
  input  logic              clk,
  input  logic [RAW_W-1:0]  raw_in,
  input  logic [CHAN_W-1:0] fog_factor,
  input  logic [CHAN_W-1:0] fog_chan,
  input  logic              fog_en,
  output logic [CHAN_W-1:0] chan_out
);

  logic [CHAN_W-1:0] clamp_c;
  logic [CHAN_W-1:0] inv_f;
  logic [PROD_W-1:0] prod_c_r, prod_c_nxt;
  logic [PROD_W-1:0] prod_f_r, prod_f_nxt;
  logic [CHAN_W-1:0] clamp_a_r;
  logic [CHAN_W-1:0] clamp_b_r;
  logic [PROD_W:0]   sum_w;
  logic [32:0]       scaled_w;
  logic [CHAN_W-1:0] fogged_r, fogged_nxt;

  // Stage 1: clamp and the two weighted products
  assign clamp_c    = clamp_chan(raw_in);
  assign inv_f      = CHAN_MAX - fog_factor;
  assign prod_c_nxt = clamp_c * fog_factor;
  assign prod_f_nxt = fog_chan * inv_f;

  // Stage 2: sum and divide by 255 via reciprocal multiply
  assign sum_w      = {1'b0, prod_c_r} + {1'b0, prod_f_r};
  assign scaled_w   = 33'(sum_w) * 33'(DIV255_MUL);
  assign fogged_nxt = scaled_w[DIV255_SHIFT+CHAN_W-1:DIV255_SHIFT];

  always_ff @(posedge clk) begin
    prod_c_r  <= prod_c_nxt;
    prod_f_r  <= prod_f_nxt;
    clamp_a_r <= clamp_c;
    clamp_b_r <= clamp_a_r;
    fogged_r  <= fogged_nxt;
  end

  assign chan_out = fog_en ? fogged_r : clamp_b_r;

endmodule

@@ rtl/pftf_merge.sv @@
// ----------------------------------------------------------------------------
// pftf_merge
// Merges the three color lanes with the fragment control: color test,
// discard zeroing and the output register.
// ----------------------------------------------------------------------------
module pftf_merge
  import pftf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  frag_ctl_t         ctl,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  input  logic              ctest_en,
  input  ctest_func_t       ctest_func,
  input  logic [23:0]       ctest_ref,
  input  logic [23:0]       ctest_mask,
  output logic              out_valid,
  output logic              out_keep,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_blue,
  output logic [CHAN_W-1:0] out_alpha
);

  logic [23:0]       col_m;
  logic [23:0]       ref_m;
  logic              ctest_pass;
  logic              keep_nxt;
  logic              valid_r;
  logic              keep_r;
  logic [CHAN_W-1:0] red_r, green_r, blue_r, alpha_r;

  // Color test on masked RGB
  assign col_m = {blue, green, red} & ctest_mask;
  assign ref_m = ctest_ref & ctest_mask;

  always_comb begin
    case (ctest_func)
      CFN_NEVER:  ctest_pass = 1'b0;
      CFN_ALWAYS: ctest_pass = 1'b1;
      CFN_EQ:     ctest_pass = (col_m == ref_m);
      CFN_NE:     ctest_pass = (col_m != ref_m);
      default:    ctest_pass = 1'b1;
    endcase
  end

  assign keep_nxt = ctl.keep & (~ctest_en | ctest_pass);

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.valid;
    end
  end

  // Result word; discarded fragments give zero color
  always_ff @(posedge clk) begin
    keep_r  <= keep_nxt;
    red_r   <= keep_nxt ? red       : '0;
    green_r <= keep_nxt ? green     : '0;
    blue_r  <= keep_nxt ? blue      : '0;
    alpha_r <= keep_nxt ? ctl.alpha : '0;
  end

  assign out_valid = valid_r;
  assign out_keep  = keep_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;
  assign out_alpha = alpha_r;

endmodule

@@ rtl/pixel_fragment_test_and_fog.sv @@
// ----------------------------------------------------------------------------
// pixel_fragment_test_and_fog
// Per-fragment depth range kill, clamp, alpha test, fog blend and color test.
//
//   channel  ports                               handshake
//   input    in_depth in_fog_factor in_*_in      start, taken when !busy
//   result   out_keep out_*_out                  out_valid strobe, one cycle
//   config   cfg_wr_en cfg_index cfg_wdata       write on cfg_wr_en
//
// One word enters every cycle; the control is registered in step with the fog lanes:
// products, reciprocal multiply, then the merge register that drives out_valid.
// busy stays low; the pipeline never holds off a word.
// rst_n is synchronous and restores the register defaults.
// The receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module pixel_fragment_test_and_fog
  import pftf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_depth,
  input  logic [7:0]  in_fog_factor,
  input  logic [31:0] in_red_in,
  input  logic [31:0] in_green_in,
  input  logic [31:0] in_blue_in,
  input  logic [31:0] in_alpha_in,
  output logic        out_valid,
  output logic        out_keep,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [7:0]  out_alpha_out,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  logic [4:0]  stage_en_r;
  logic [15:0] depth_min_r;
  logic [15:0] depth_max_r;
  logic [23:0] alpha_set_r;
  logic [23:0] fog_rgb_r;
  logic [1:0]  ctest_func_r;
  logic [23:0] ctest_ref_r;
  logic [23:0] ctest_mask_r;

  logic              accept;
  logic [CHAN_W-1:0] alpha_c;
  logic [CHAN_W-1:0] alpha_m;
  logic [CHAN_W-1:0] alpha_ref;
  logic              depth_ok;
  logic              alpha_ok;
  frag_ctl_t         ctl_a_r, ctl_a_nxt;
  frag_ctl_t         ctl_b_r;
  logic [CHAN_W-1:0] red_l, green_l, blue_l;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_en_r   <= '0;
      depth_min_r  <= '0;
      depth_max_r  <= 16'hFFFF;
      alpha_set_r  <= 24'd1;
      fog_rgb_r    <= '0;
      ctest_func_r <= 2'd1;
      ctest_ref_r  <= '0;
      ctest_mask_r <= 24'hFFFFFF;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_STAGE_EN:   stage_en_r   <= cfg_wdata[4:0];
        REG_DEPTH_MIN:  depth_min_r  <= cfg_wdata[15:0];
        REG_DEPTH_MAX:  depth_max_r  <= cfg_wdata[15:0];
        REG_ALPHA_SET:  alpha_set_r  <= cfg_wdata;
        REG_FOG_RGB:    fog_rgb_r    <= cfg_wdata;
        REG_CTEST_FUNC: ctest_func_r <= cfg_wdata[1:0];
        REG_CTEST_REF:  ctest_ref_r  <= cfg_wdata;
        REG_CTEST_MASK: ctest_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Depth range test
  assign depth_ok = ~stage_en_r[EN_DEPTH] |
                    ((in_depth >= depth_min_r) & (in_depth <= depth_max_r));

  // Alpha clamp, optional mask and compare
  assign alpha_c   = clamp_chan(in_alpha_in);
  assign alpha_m   = stage_en_r[EN_AMASK] ? (alpha_c & alpha_set_r[23:16]) : alpha_c;
  assign alpha_ref = alpha_set_r[15:8];

  always_comb begin
    case (alpha_func_t'(alpha_set_r[2:0]))
      AFN_NEVER:  alpha_ok = 1'b0;
      AFN_ALWAYS: alpha_ok = 1'b1;
      AFN_EQ:     alpha_ok = (alpha_m == alpha_ref);
      AFN_NE:     alpha_ok = (alpha_m != alpha_ref);
      AFN_LT:     alpha_ok = (alpha_m <  alpha_ref);
      AFN_LE:     alpha_ok = (alpha_m <= alpha_ref);
      AFN_GT:     alpha_ok = (alpha_m >  alpha_ref);
      AFN_GE:     alpha_ok = (alpha_m >= alpha_ref);
      default:    alpha_ok = 1'b1;
    endcase
  end

  always_comb begin
    ctl_a_nxt.valid = accept;
    ctl_a_nxt.keep  = depth_ok & alpha_ok;
    ctl_a_nxt.alpha = alpha_c;
  end

  // Control pipeline matched to the lane latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r.valid <= 1'b0;
      ctl_b_r.valid <= 1'b0;
    end else begin
      ctl_a_r.valid <= ctl_a_nxt.valid;
      ctl_b_r.valid <= ctl_a_r.valid;
    end
    ctl_a_r.keep  <= ctl_a_nxt.keep;
    ctl_a_r.alpha <= ctl_a_nxt.alpha;
    ctl_b_r.keep  <= ctl_a_r.keep;
    ctl_b_r.alpha <= ctl_a_r.alpha;
  end

  // Color lanes
  pftf_lane u_lane_red (
    .clk        (clk),
    .raw_in     (in_red_in),
    .fog_factor (in_fog_factor),
    .fog_chan   (fog_rgb_r[7:0]),
    .fog_en     (stage_en_r[EN_FOG]),
    .chan_out   (red_l)
  );

  pftf_lane u_lane_green (
    .clk        (clk),
    .raw_in     (in_green_in),
    .fog_factor (in_fog_factor),
    .fog_chan   (fog_rgb_r[15:8]),
    .fog_en     (stage_en_r[EN_FOG]),
    .chan_out   (green_l)
  );

  pftf_lane u_lane_blue (
    .clk        (clk),
    .raw_in     (in_blue_in),
    .fog_factor (in_fog_factor),
    .fog_chan   (fog_rgb_r[23:16]),
    .fog_en     (stage_en_r[EN_FOG]),
    .chan_out   (blue_l)
  );

  // Color test and result register
  pftf_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl_b_r),
    .red        (red_l),
    .green      (green_l),
    .blue       (blue_l),
    .ctest_en   (stage_en_r[EN_CTEST] & ~stage_en_r[EN_CLEAR]),
    .ctest_func (ctest_func_t'(ctest_func_r)),
    .ctest_ref  (ctest_ref_r),
    .ctest_mask (ctest_mask_r),
    .out_valid  (out_valid),
    .out_keep   (out_keep),
    .out_red    (out_red_out),
    .out_green  (out_green_out),
    .out_blue   (out_blue_out),
    .out_alpha  (out_alpha_out)
  );

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pixel_fragment_test_and_fog. Fragment words go in
// through the start/busy port, each accepted word is scored by a local
// predictor of the depth range, clamp, alpha test, fog blend and color test,
// and every out_valid strobe is matched field by field in arrival order.
// Registers are rewritten only once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_top;
  import pftf_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_WORDS  = 1950;
  localparam int DRAIN_CYCLES  = 6;

  // One fragment word as driven on the in_ ports
  typedef struct {
    logic [15:0]        depth;
    logic [7:0]         fog_factor;
    logic signed [31:0] red;
    logic signed [31:0] green;
    logic signed [31:0] blue;
    logic signed [31:0] alpha;
  } frag_t;

  // One result word as seen on the out_ ports
  typedef struct {
    logic       keep;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } frag_result_t;

  // Register file image
  typedef struct {
    logic [4:0]  stage_en;
    logic [15:0] depth_min;
    logic [15:0] depth_max;
    logic [23:0] alpha_setup;
    logic [23:0] fog_rgb;
    logic [1:0]  ctest_func;
    logic [23:0] ctest_ref;
    logic [23:0] ctest_mask;
  } pipe_cfg_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_depth;
  logic [7:0]  in_fog_factor;
  logic [31:0] in_red_in;
  logic [31:0] in_green_in;
  logic [31:0] in_blue_in;
  logic [31:0] in_alpha_in;
  logic        out_valid;
  logic        out_keep;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;
  logic [7:0]  out_alpha_out;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_wdata;

  pipe_cfg_t    cfg_shadow;
  frag_result_t pending_results[$];
  int           error_count;
  int           frags_scored;
  int           frags_kept;
  int           settings_used;
  int           cycle_count;

  pixel_fragment_test_and_fog u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_depth      (in_depth),
    .in_fog_factor (in_fog_factor),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .in_alpha_in   (in_alpha_in),
    .out_valid     (out_valid),
    .out_keep      (out_keep),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_alpha_out (out_alpha_out),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Saturate signed channel to 0..255
  function automatic logic [7:0] sat_channel(input logic signed [31:0] v);
    if (v < 0) return 8'h00;
    if (v > 255) return 8'hFF;
    return v[7:0];
  endfunction

  // Blend toward fog color, divide by 255 via reciprocal multiply (32-bit wrap)
  function automatic logic [7:0] fog_channel(input logic [7:0] c, input logic [7:0] fc,
                                             input logic [7:0] fw);
    logic [31:0] blend;
    logic [31:0] scaled;
    blend  = 32'(c) * 32'(fw) + 32'(fc) * (32'd255 - 32'(fw));
    scaled = blend * 32'(DIV255_MUL);
    return scaled[DIV255_SHIFT +: 8];
  endfunction

  function automatic frag_result_t fragment_outcome(input frag_t f, input pipe_cfg_t c);
    frag_result_t res;
    logic [7:0]   r, g, b, a, am, aref;
    logic [23:0]  col, cref;
    logic         apass;
    r = sat_channel(f.red);
    g = sat_channel(f.green);
    b = sat_channel(f.blue);
    a = sat_channel(f.alpha);
    res.keep = 1'b1;
    // depth range kill
    if (c.stage_en[EN_DEPTH] && (f.depth < c.depth_min || f.depth > c.depth_max))
      res.keep = 1'b0;
    // alpha test
    am   = c.stage_en[EN_AMASK] ? (a & c.alpha_setup[23:16]) : a;
    aref = c.alpha_setup[15:8];
    case (alpha_func_t'(c.alpha_setup[2:0]))
      AFN_NEVER:  apass = 1'b0;
      AFN_ALWAYS: apass = 1'b1;
      AFN_EQ:     apass = (am == aref);
      AFN_NE:     apass = (am != aref);
      AFN_LT:     apass = (am < aref);
      AFN_LE:     apass = (am <= aref);
      AFN_GT:     apass = (am > aref);
      default:    apass = (am >= aref);
    endcase
    if (!apass) res.keep = 1'b0;
    // fog on RGB only
    if (c.stage_en[EN_FOG]) begin
      r = fog_channel(r, c.fog_rgb[7:0], f.fog_factor);
      g = fog_channel(g, c.fog_rgb[15:8], f.fog_factor);
      b = fog_channel(b, c.fog_rgb[23:16], f.fog_factor);
    end
    // color test, bypassed in clear mode
    if (res.keep && c.stage_en[EN_CTEST] && !c.stage_en[EN_CLEAR]) begin
      col  = {b, g, r} & c.ctest_mask;
      cref = c.ctest_ref & c.ctest_mask;
      case (ctest_func_t'(c.ctest_func))
        CFN_NEVER:  res.keep = 1'b0;
        CFN_ALWAYS: res.keep = res.keep;
        CFN_EQ:     res.keep = (col == cref);
        default:    res.keep = (col != cref);
      endcase
    end
    if (res.keep) begin
      res.red   = r;
      res.green = g;
      res.blue  = b;
      res.alpha = a;
    end else begin
      res.red   = 8'h00;
      res.green = 8'h00;
      res.blue  = 8'h00;
      res.alpha = 8'h00;
    end
    return res;
  endfunction

  // Score each accepted word against the register image in force
  always @(posedge clk) begin
    frag_t w;
    if (rst_n && start && busy === 1'b0) begin
      w.depth      = in_depth;
      w.fog_factor = in_fog_factor;
      w.red        = in_red_in;
      w.green      = in_green_in;
      w.blue       = in_blue_in;
      w.alpha      = in_alpha_in;
      pending_results.insert(pending_results.size(), fragment_outcome(w, cfg_shadow));
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    frag_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result word with no fragment outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("keep", {7'd0, want.keep}, {7'd0, out_keep});
        check_field("red_out", want.red, out_red_out);
        check_field("green_out", want.green, out_green_out);
        check_field("blue_out", want.blue, out_blue_out);
        check_field("alpha_out", want.alpha, out_alpha_out);
        frags_scored++;
        if (want.keep) frags_kept++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pixel_fragment_test_and_fog: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Hold start until the word is taken
  task automatic send_fragment(input frag_t f);
    in_depth      <= f.depth;
    in_fog_factor <= f.fog_factor;
    in_red_in     <= f.red;
    in_green_in   <= f.green;
    in_blue_in    <= f.blue;
    in_alpha_in   <= f.alpha;
    start         <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Full register rewrite, only with the pipeline empty
  task automatic set_config(input pipe_cfg_t c);
    drain_pipeline();
    write_reg(REG_STAGE_EN, {19'd0, c.stage_en});
    write_reg(REG_DEPTH_MIN, {8'd0, c.depth_min});
    write_reg(REG_DEPTH_MAX, {8'd0, c.depth_max});
    write_reg(REG_ALPHA_SET, c.alpha_setup);
    write_reg(REG_FOG_RGB, c.fog_rgb);
    write_reg(REG_CTEST_FUNC, {22'd0, c.ctest_func});
    write_reg(REG_CTEST_REF, c.ctest_ref);
    write_reg(REG_CTEST_MASK, c.ctest_mask);
    cfg_wr_en  <= 1'b0;
    cfg_shadow = c;
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic pipe_cfg_t reset_setting();
    pipe_cfg_t c;
    c.stage_en    = '0;
    c.depth_min   = 16'h0000;
    c.depth_max   = 16'hFFFF;
    c.alpha_setup = {16'd0, 5'd0, AFN_ALWAYS};
    c.fog_rgb     = '0;
    c.ctest_func  = CFN_ALWAYS;
    c.ctest_ref   = '0;
    c.ctest_mask  = 24'hFFFFFF;
    return c;
  endfunction

  function automatic logic [23:0] alpha_word(input alpha_func_t fn, input logic [7:0] aref,
                                             input logic [7:0] amask);
    return {amask, aref, 5'd0, fn};
  endfunction

  function automatic frag_t mk_frag(input logic [15:0] depth, input logic [7:0] fw,
                                    input logic signed [31:0] r, input logic signed [31:0] g,
                                    input logic signed [31:0] b, input logic signed [31:0] a);
    frag_t f;
    f.depth      = depth;
    f.fog_factor = fw;
    f.red        = r;
    f.green      = g;
    f.blue       = b;
    f.alpha      = a;
    return f;
  endfunction

  // Channel value: mostly in range, some far out either way, some at a hint
  function automatic logic signed [31:0] rand_channel(input logic [7:0] hint);
    logic signed [31:0] v;
    case ($urandom_range(0, 11))
      0:       v = $urandom;
      1:       v = $urandom_range(256, 100000);
      2:       v = 32'd0 - $urandom_range(1, 100000);
      3, 4, 5: v = {24'd0, hint};
      default: v = $urandom_range(0, 255);
    endcase
    return v;
  endfunction

  function automatic pipe_cfg_t random_setting();
    pipe_cfg_t c;
    c.stage_en    = 5'($urandom_range(0, 31));
    c.depth_min   = 16'($urandom_range(0, 65535));
    c.depth_max   = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 2) != 0 && c.depth_min > c.depth_max) begin
      c.depth_min = c.depth_max;
      c.depth_max = 16'($urandom_range(0, 65535)) | c.depth_min;
    end
    c.alpha_setup = 24'($urandom_range(0, 24'hFFFFFF));
    if ($urandom_range(0, 1)) c.alpha_setup[23:16] = 8'hFF;
    c.fog_rgb     = 24'($urandom_range(0, 24'hFFFFFF));
    c.ctest_func  = 2'($urandom_range(0, 3));
    c.ctest_ref   = 24'($urandom_range(0, 24'hFFFFFF));
    case ($urandom_range(0, 3))
      0:       c.ctest_mask = 24'hFFFFFF;
      1:       c.ctest_mask = 24'h0000F0 << (8 * $urandom_range(0, 2));
      2:       c.ctest_mask = 24'h000000;
      default: c.ctest_mask = 24'($urandom_range(0, 24'hFFFFFF));
    endcase
    return c;
  endfunction

  // Random fragment, biased toward the edges of the current setting
  function automatic frag_t random_fragment(input pipe_cfg_t c);
    frag_t       f;
    logic [23:0] hint;
    case ($urandom_range(0, 7))
      0:       f.depth = c.depth_min;
      1:       f.depth = c.depth_min - 16'd1;
      2:       f.depth = c.depth_max;
      3:       f.depth = c.depth_max + 16'd1;
      default: f.depth = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 5))
      0:       f.fog_factor = 8'h00;
      1:       f.fog_factor = 8'hFF;
      default: f.fog_factor = 8'($urandom_range(0, 255));
    endcase
    hint    = ($urandom_range(0, 2) == 0) ? c.ctest_ref
                                          : 24'($urandom_range(0, 24'hFFFFFF));
    f.red   = rand_channel(hint[7:0]);
    f.green = rand_channel(hint[15:8]);
    f.blue  = rand_channel(hint[23:16]);
    f.alpha = rand_channel(c.alpha_setup[15:8] + 8'($urandom_range(0, 2)) - 8'd1);
    return f;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Clamp extremes under the power-on register values
  task automatic test_reset_defaults();
    send_fragment(mk_frag(16'h0000, 8'h00, 32'h80000000, 32'h7FFFFFFF, -1, 256));
    send_fragment(mk_frag(16'hFFFF, 8'hFF, 0, 255, 32'hFFFFFF00, 1));
    send_fragment(mk_frag(16'h8000, 8'h80, 128, 254, 255, 32'h00000100));
  endtask

  // Every alpha function, with the alpha mask on
  task automatic test_alpha_functions();
    pipe_cfg_t   c;
    alpha_func_t afn;
    afn = afn.first();
    do begin
      c = reset_setting();
      c.stage_en[EN_AMASK] = 1'b1;
      c.alpha_setup = alpha_word(afn, 8'h80, 8'hF0);
      set_config(c);
      send_fragment(mk_frag(16'h1234, 8'h40, 10, 20, 30, 32'h8F));
      afn = afn.next();
    end while (afn != afn.first());
  endtask

  // Range edges, then crossed bounds
  task automatic test_depth_range();
    pipe_cfg_t c;
    c = reset_setting();
    c.stage_en[EN_DEPTH] = 1'b1;
    c.depth_min = 16'd100;
    c.depth_max = 16'd200;
    set_config(c);
    send_fragment(mk_frag(16'd99, 8'h00, 1, 2, 3, 4));
    send_fragment(mk_frag(16'd100, 8'h00, 1, 2, 3, 4));
    send_fragment(mk_frag(16'd200, 8'h00, 1, 2, 3, 4));
    send_fragment(mk_frag(16'd201, 8'h00, 1, 2, 3, 4));
    c.depth_min = 16'd300;
    set_config(c);
    send_fragment(mk_frag(16'd250, 8'h00, 1, 2, 3, 4));
  endtask

  // Full fog, no fog, half fog
  task automatic test_fog_blend();
    pipe_cfg_t c;
    c = reset_setting();
    c.stage_en[EN_FOG] = 1'b1;
    c.fog_rgb = 24'h4080C0;
    set_config(c);
    send_fragment(mk_frag(16'h0000, 8'h00, 255, 0, 77, 200));
    send_fragment(mk_frag(16'h0000, 8'hFF, 255, 0, 77, 200));
    send_fragment(mk_frag(16'h0000, 8'h80, 300, -5, 77, 200));
  endtask

  // Color test: equal, not equal, clear-mode bypass, never
  task automatic test_color_test();
    pipe_cfg_t c;
    frag_t     f;
    f = mk_frag(16'h0000, 8'h00, 32'h0C, 32'h0B, 32'h0A, 32'hFF);
    c = reset_setting();
    c.stage_en[EN_CTEST] = 1'b1;
    c.ctest_ref  = 24'h0A0B0C;
    c.ctest_func = CFN_EQ;
    set_config(c);
    send_fragment(f);
    c.ctest_func = CFN_NE;
    set_config(c);
    send_fragment(f);
    c.stage_en[EN_CLEAR] = 1'b1;
    set_config(c);
    send_fragment(f);
    c.stage_en[EN_CLEAR] = 1'b0;
    c.ctest_func = CFN_NEVER;
    set_config(c);
    send_fragment(f);
  endtask

  // Random settings and fragments, sent in bursts with random gaps
  task automatic test_random_traffic();
    pipe_cfg_t c;
    int        sent;
    int        phase;
    int        phase_words;
    int        burst;
    bit        gaps_on;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      c = random_setting();
      // register extremes first: everything high, then everything low
      if (phase == 0) begin
        c.stage_en    = '1;
        c.depth_min   = '1;
        c.depth_max   = '1;
        c.alpha_setup = '1;
        c.fog_rgb     = '1;
        c.ctest_func  = '1;
        c.ctest_ref   = '1;
        c.ctest_mask  = '1;
      end else if (phase == 1) begin
        c.stage_en    = '0;
        c.depth_min   = '0;
        c.depth_max   = '0;
        c.alpha_setup = '0;
        c.fog_rgb     = '0;
        c.ctest_func  = '0;
        c.ctest_ref   = '0;
        c.ctest_mask  = '0;
      end
      set_config(c);
      phase_words = $urandom_range(40, 90);
      gaps_on     = ($urandom_range(0, 3) != 0);
      burst       = $urandom_range(1, 24);
      for (int k = 0; k < phase_words; k++) begin
        send_fragment(random_fragment(c));
        sent++;
        burst--;
        if (burst == 0) begin
          if (gaps_on) idle_cycles($urandom_range(1, 5));
          burst = $urandom_range(1, 24);
        end
      end
      phase++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_depth      = '0;
    in_fog_factor = '0;
    in_red_in     = '0;
    in_green_in   = '0;
    in_blue_in    = '0;
    in_alpha_in   = '0;
    cfg_wr_en     = 1'b0;
    cfg_index     = REG_STAGE_EN;
    cfg_wdata     = '0;
    cfg_shadow    = reset_setting();
    error_count   = 0;
    frags_scored  = 0;
    frags_kept    = 0;
    settings_used = 0;
    cycle_count   = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_alpha_functions();
    test_depth_range();
    test_fog_blend();
    test_color_test();
    test_random_traffic();
    drain_pipeline();

    $display("Scored %0d fragment words, %0d kept, across %0d register settings.",
             frags_scored, frags_kept, settings_used);
    $display("Covered all alpha and color test functions, depth range, fog and clear mode.");
    if (error_count == 0) begin
      $display("pixel_fragment_test_and_fog: match");
    end else begin
      $display("pixel_fragment_test_and_fog: mismatch");
    end
    $finish;
  end

endmodule

@@ pixel_fragment_test_and_fog.f @@
rtl/pftf_pkg.sv
rtl/pftf_lane.sv
rtl/pftf_merge.sv
rtl/pixel_fragment_test_and_fog.sv
bench/tb_top.sv
